[hw/rtl/tsf_pkg.sv]
// Shared types, widths and helpers for the triangle span fill block.
`timescale 1ns / 1ps
`default_nettype none
package tsf_pkg;

    localparam int COL_W = 7;
    localparam int ROW_W = 6;
    localparam int NUM_W = COL_W + ROW_W;
    localparam int CNT_W = ROW_W + 1;

    localparam int SCREEN_WIDTH        = 128;
    localparam int SCREEN_HEIGHT       = 64;
    localparam int SLOPE_FRAC_BITS_DEF = 16;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLASS,
        S_MUL0,
        S_MUL1,
        S_SPLIT_GO,
        S_SPLIT_WAIT,
        S_S1_GO,
        S_S1_WAIT,
        S_S2_GO,
        S_S2_WAIT,
        S_EMIT
    } t_state;

    function automatic logic [COL_W-1:0] sat_col(input logic [COL_W-1:0] v);
        if (int'(v) > SCREEN_WIDTH - 1) begin
            return COL_W'(SCREEN_WIDTH - 1);
        end
        return v;
    endfunction

    function automatic logic [ROW_W-1:0] sat_row(input logic [ROW_W-1:0] v);
        if (int'(v) > SCREEN_HEIGHT - 1) begin
            return ROW_W'(SCREEN_HEIGHT - 1);
        end
        return v;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/tsf_if.sv]
// Valid/ready channel interfaces for triangle beats and span beats.
`timescale 1ns / 1ps
`default_nettype none
interface tsf_tri_if;
    logic                      valid;
    logic                      ready;
    logic [tsf_pkg::COL_W-1:0] x0;
    logic [tsf_pkg::ROW_W-1:0] y0;
    logic [tsf_pkg::COL_W-1:0] x1;
    logic [tsf_pkg::ROW_W-1:0] y1;
    logic [tsf_pkg::COL_W-1:0] x2;
    logic [tsf_pkg::ROW_W-1:0] y2;

    modport source (output valid, x0, y0, x1, y1, x2, y2, input ready);
    modport sink   (input valid, x0, y0, x1, y1, x2, y2, output ready);
endinterface

interface tsf_span_if;
    logic                      valid;
    logic                      ready;
    logic [tsf_pkg::ROW_W-1:0] span_row;
    logic [tsf_pkg::COL_W-1:0] span_left;
    logic [tsf_pkg::COL_W-1:0] span_right;
    logic                      last_span;

    modport source (output valid, span_row, span_left, span_right, last_span, input ready);
    modport sink   (input valid, span_row, span_left, span_right, last_span, output ready);
endinterface
`default_nettype wire

[hw/rtl/triangle_scanline_span_fill.sv]
// Scanline triangle rasterizer: one triangle in, one span beat per covered row out.
//
// Channels: i_tri takes one triangle beat (three vertices, columns 7 bits, rows
// 6 bits). o_span gives one beat per covered row: row, left and right columns
// (inclusive, left <= right) and last_span on the final beat of the triangle.
// Vertices are sorted by row; flat-bottom triangles fill top-down, flat-top
// triangles bottom-up, general triangles split at the middle row (upper half
// top-down, then lower half bottom-up). All rows equal gives one span.
// One shared restoring divider computes the split column and the inverse
// slopes in turn; a degenerate triangle uses no divider. While emitting, one
// span leaves per cycle unless the receiver stalls.
// i_tri.ready is high only while the sequencer is idle; the next triangle can
// be taken while the final span still sits in the output register.
// Reset (synchronous, active low) returns the sequencer to idle and drops
// o_span.valid. When the receiver stalls, the output register holds its beat
// and span generation pauses until it is taken.
`timescale 1ns / 1ps
`default_nettype none
module triangle_scanline_span_fill #(
    parameter int SLOPE_FRAC_BITS = tsf_pkg::SLOPE_FRAC_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tsf_tri_if.sink   i_tri,
    tsf_span_if.source o_span
);

    localparam int COL_W = tsf_pkg::COL_W;
    localparam int ROW_W = tsf_pkg::ROW_W;
    localparam int NUM_W = tsf_pkg::NUM_W;
    localparam int CNT_W = tsf_pkg::CNT_W;
    localparam int F     = SLOPE_FRAC_BITS;
    localparam int DVD_W = COL_W + F;      // |dx| << F
    localparam int SW    = DVD_W + 1;      // signed slope
    localparam int EW    = DVD_W + 2;      // signed edge accumulator

    tsf_pkg::t_state r_state, n_state;

    // sorted vertices
    logic [COL_W-1:0] r_sx [0:2];
    logic [ROW_W-1:0] r_sy [0:2];
    logic [COL_W-1:0] n_sx [0:2];
    logic [ROW_W-1:0] n_sy [0:2];

    // current fill part: apex column, two far columns, height, start row
    logic [NUM_W-1:0] r_num,   n_num;
    logic [COL_W-1:0] r_split, n_split;
    logic [COL_W-1:0] r_ax,    n_ax;
    logic [COL_W-1:0] r_px,    n_px;
    logic [COL_W-1:0] r_qx,    n_qx;
    logic [ROW_W-1:0] r_dy,    n_dy;
    logic [ROW_W-1:0] r_row,   n_row;
    logic [CNT_W-1:0] r_cnt,   n_cnt;
    logic             r_up,    n_up;
    logic             r_more,  n_more;
    logic             r_neg,   n_neg;
    logic signed [SW-1:0] r_s1, n_s1, r_s2, n_s2;
    logic signed [EW-1:0] r_e1, n_e1, r_e2, n_e2;

    // output register
    logic             r_out_valid, n_out_valid;
    logic [ROW_W-1:0] r_out_row,   n_out_row;
    logic [COL_W-1:0] r_out_left,  n_out_left;
    logic [COL_W-1:0] r_out_right, n_out_right;
    logic             r_out_last,  n_out_last;

    // shared arithmetic
    logic             w_div_start;
    logic [DVD_W-1:0] w_div_dividend;
    logic [ROW_W-1:0] w_div_divisor;
    logic             w_div_done;
    logic [DVD_W-1:0] w_div_quo;
    logic [COL_W-1:0] w_mul_a;
    logic [ROW_W-1:0] w_mul_b;
    logic [NUM_W-1:0] w_prod;

    // sorter temporaries
    logic [COL_W-1:0] w_cx [0:2];
    logic [ROW_W-1:0] w_cy [0:2];
    logic [COL_W-1:0] w_tx;
    logic [ROW_W-1:0] w_ty;

    logic             w_accept;
    logic             w_out_free;
    logic [COL_W-1:0] w_far;
    logic [COL_W-1:0] w_mag;
    logic signed [SW-1:0] w_slope;
    logic signed [EW-1:0] w_e_init;
    logic [COL_W-1:0] w_t1, w_t2;

    assign w_accept   = i_tri.valid && i_tri.ready;
    assign w_out_free = !r_out_valid || o_span.ready;

    // Row sort network on the incoming beat: 0/1, 0/2, 1/2, strict compare.
    always_comb begin
        w_tx    = '0;
        w_ty    = '0;
        w_cx[0] = tsf_pkg::sat_col(i_tri.x0);
        w_cy[0] = tsf_pkg::sat_row(i_tri.y0);
        w_cx[1] = tsf_pkg::sat_col(i_tri.x1);
        w_cy[1] = tsf_pkg::sat_row(i_tri.y1);
        w_cx[2] = tsf_pkg::sat_col(i_tri.x2);
        w_cy[2] = tsf_pkg::sat_row(i_tri.y2);
        if (w_cy[0] > w_cy[1]) begin
            w_tx = w_cx[0]; w_cx[0] = w_cx[1]; w_cx[1] = w_tx;
            w_ty = w_cy[0]; w_cy[0] = w_cy[1]; w_cy[1] = w_ty;
        end
        if (w_cy[0] > w_cy[2]) begin
            w_tx = w_cx[0]; w_cx[0] = w_cx[2]; w_cx[2] = w_tx;
            w_ty = w_cy[0]; w_cy[0] = w_cy[2]; w_cy[2] = w_ty;
        end
        if (w_cy[1] > w_cy[2]) begin
            w_tx = w_cx[1]; w_cx[1] = w_cx[2]; w_cx[2] = w_tx;
            w_ty = w_cy[1]; w_cy[1] = w_cy[2]; w_cy[2] = w_ty;
        end
    end

    // Shared multiplier for the split numerator:
    // x0*(y2-y1) + x2*(y1-y0), one term in S_MUL0 and one in S_MUL1.
    always_comb begin
        if (r_state == tsf_pkg::S_MUL0) begin
            w_mul_a = r_sx[0];
            w_mul_b = r_sy[2] - r_sy[1];
        end else begin
            w_mul_a = r_sx[2];
            w_mul_b = r_sy[1] - r_sy[0];
        end
        w_prod = NUM_W'(w_mul_a) * NUM_W'(w_mul_b);
    end

    // Divider operands: split column, or |far - apex| << F over the part height.
    always_comb begin
        w_far = (r_state == tsf_pkg::S_S2_GO) ? r_qx : r_px;
        w_mag = (w_far >= r_ax) ? (w_far - r_ax) : (r_ax - w_far);
        if (r_state == tsf_pkg::S_SPLIT_GO) begin
            w_div_dividend = DVD_W'(r_num);
            w_div_divisor  = r_sy[2] - r_sy[0];
        end else begin
            w_div_dividend = {w_mag, {F{1'b0}}};
            w_div_divisor  = r_dy;
        end
        w_slope  = r_neg ? -$signed({1'b0, w_div_quo}) : $signed({1'b0, w_div_quo});
        w_e_init = $signed({2'b00, r_ax, {F{1'b0}}});
        w_t1     = r_e1[F +: COL_W];
        w_t2     = r_e2[F +: COL_W];
    end

    tsf_div #(
        .DVD_W (DVD_W),
        .DVS_W (ROW_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_div_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tsf_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sx        <= n_sx;
        r_sy        <= n_sy;
        r_num       <= n_num;
        r_split     <= n_split;
        r_ax        <= n_ax;
        r_px        <= n_px;
        r_qx        <= n_qx;
        r_dy        <= n_dy;
        r_row       <= n_row;
        r_cnt       <= n_cnt;
        r_up        <= n_up;
        r_more      <= n_more;
        r_neg       <= n_neg;
        r_s1        <= n_s1;
        r_s2        <= n_s2;
        r_e1        <= n_e1;
        r_e2        <= n_e2;
        r_out_row   <= n_out_row;
        r_out_left  <= n_out_left;
        r_out_right <= n_out_right;
        r_out_last  <= n_out_last;
    end

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_sx        = r_sx;
        n_sy        = r_sy;
        n_num       = r_num;
        n_split     = r_split;
        n_ax        = r_ax;
        n_px        = r_px;
        n_qx        = r_qx;
        n_dy        = r_dy;
        n_row       = r_row;
        n_cnt       = r_cnt;
        n_up        = r_up;
        n_more      = r_more;
        n_neg       = r_neg;
        n_s1        = r_s1;
        n_s2        = r_s2;
        n_e1        = r_e1;
        n_e2        = r_e2;
        n_out_valid = r_out_valid;
        n_out_row   = r_out_row;
        n_out_left  = r_out_left;
        n_out_right = r_out_right;
        n_out_last  = r_out_last;
        w_div_start = 1'b0;

        if (r_out_valid && o_span.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            tsf_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_sx    = w_cx;
                    n_sy    = w_cy;
                    n_state = tsf_pkg::S_CLASS;
                end
            end
            tsf_pkg::S_CLASS: begin
                if (r_sy[0] == r_sy[2]) begin
                    // degenerate: single point span, no slopes
                    n_ax    = r_sx[0];
                    n_row   = r_sy[0];
                    n_cnt   = CNT_W'(1);
                    n_up    = 1'b0;
                    n_more  = 1'b0;
                    n_e1    = $signed({2'b00, r_sx[0], {F{1'b0}}});
                    n_e2    = $signed({2'b00, r_sx[0], {F{1'b0}}});
                    n_s1    = '0;
                    n_s2    = '0;
                    n_state = tsf_pkg::S_EMIT;
                end else if (r_sy[1] == r_sy[2]) begin
                    // flat bottom: apex on top, rows y0..y1
                    n_ax    = r_sx[0];
                    n_px    = r_sx[1];
                    n_qx    = r_sx[2];
                    n_dy    = r_sy[1] - r_sy[0];
                    n_row   = r_sy[0];
                    n_cnt   = CNT_W'(r_sy[1] - r_sy[0]) + CNT_W'(1);
                    n_up    = 1'b0;
                    n_more  = 1'b0;
                    n_state = tsf_pkg::S_S1_GO;
                end else if (r_sy[0] == r_sy[1]) begin
                    // flat top: apex at bottom, rows y2 down to y0+1
                    n_ax    = r_sx[2];
                    n_px    = r_sx[0];
                    n_qx    = r_sx[1];
                    n_dy    = r_sy[2] - r_sy[0];
                    n_row   = r_sy[2];
                    n_cnt   = CNT_W'(r_sy[2] - r_sy[0]);
                    n_up    = 1'b1;
                    n_more  = 1'b0;
                    n_state = tsf_pkg::S_S1_GO;
                end else begin
                    n_state = tsf_pkg::S_MUL0;
                end
            end
            tsf_pkg::S_MUL0: begin
                n_num   = w_prod;
                n_state = tsf_pkg::S_MUL1;
            end
            tsf_pkg::S_MUL1: begin
                n_num   = r_num + w_prod;
                n_state = tsf_pkg::S_SPLIT_GO;
            end
            tsf_pkg::S_SPLIT_GO: begin
                w_div_start = 1'b1;
                n_state     = tsf_pkg::S_SPLIT_WAIT;
            end
            tsf_pkg::S_SPLIT_WAIT: begin
                if (w_div_done) begin
                    // upper half first: apex on top, base at the middle row
                    n_split = w_div_quo[COL_W-1:0];
                    n_ax    = r_sx[0];
                    n_px    = r_sx[1];
                    n_qx    = w_div_quo[COL_W-1:0];
                    n_dy    = r_sy[1] - r_sy[0];
                    n_row   = r_sy[0];
                    n_cnt   = CNT_W'(r_sy[1] - r_sy[0]) + CNT_W'(1);
                    n_up    = 1'b0;
                    n_more  = 1'b1;
                    n_state = tsf_pkg::S_S1_GO;
                end
            end
            tsf_pkg::S_S1_GO: begin
                w_div_start = 1'b1;
                n_neg       = (r_px < r_ax);
                n_state     = tsf_pkg::S_S1_WAIT;
            end
            tsf_pkg::S_S1_WAIT: begin
                if (w_div_done) begin
                    n_s1    = w_slope;
                    n_state = tsf_pkg::S_S2_GO;
                end
            end
            tsf_pkg::S_S2_GO: begin
                w_div_start = 1'b1;
                n_neg       = (r_qx < r_ax);
                n_state     = tsf_pkg::S_S2_WAIT;
            end
            tsf_pkg::S_S2_WAIT: begin
                if (w_div_done) begin
                    n_s2    = w_slope;
                    n_e1    = w_e_init;
                    n_e2    = w_e_init;
                    n_state = tsf_pkg::S_EMIT;
                end
            end
            tsf_pkg::S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_row   = r_row;
                    n_out_left  = (w_t1 > w_t2) ? w_t2 : w_t1;
                    n_out_right = (w_t1 > w_t2) ? w_t1 : w_t2;
                    n_out_last  = (r_cnt == CNT_W'(1)) && !r_more;
                    n_e1        = r_e1 + {r_s1[SW-1], r_s1};
                    n_e2        = r_e2 + {r_s2[SW-1], r_s2};
                    n_row       = r_up ? (r_row - ROW_W'(1)) : (r_row + ROW_W'(1));
                    n_cnt       = r_cnt - CNT_W'(1);
                    if (r_cnt == CNT_W'(1)) begin
                        if (r_more) begin
                            // lower half: apex at bottom, rows y2 down to y1+1
                            n_ax    = r_sx[2];
                            n_px    = r_sx[1];
                            n_qx    = r_split;
                            n_dy    = r_sy[2] - r_sy[1];
                            n_row   = r_sy[2];
                            n_cnt   = CNT_W'(r_sy[2] - r_sy[1]);
                            n_up    = 1'b1;
                            n_more  = 1'b0;
                            n_state = tsf_pkg::S_S1_GO;
                        end else begin
                            n_state = tsf_pkg::S_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = tsf_pkg::S_IDLE;
            end
        endcase
    end

    assign i_tri.ready       = (r_state == tsf_pkg::S_IDLE);
    assign o_span.valid      = r_out_valid;
    assign o_span.span_row   = r_out_row;
    assign o_span.span_left  = r_out_left;
    assign o_span.span_right = r_out_right;
    assign o_span.last_span  = r_out_last;

`ifndef SYNTH
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_tri.valid && i_tri.ready) |=> !i_tri.ready)
        else $error("triangle taken while previous one still in work");

    a_div_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == tsf_pkg::S_SPLIT_WAIT || r_state == tsf_pkg::S_S1_WAIT
                        || r_state == tsf_pkg::S_S2_WAIT))
        else $error("divider finished outside a wait state");

    a_span_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_span.valid |-> (o_span.span_left <= o_span.span_right))
        else $error("span left beyond right");

    a_emit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tsf_pkg::S_EMIT) |-> (r_cnt != '0))
        else $error("emitting with no rows left");
`endif

endmodule
`default_nettype wire

[hw/rtl/tsf_div.sv]
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module tsf_div #(
    parameter int DVD_W = 23,
    parameter int DVS_W = 6
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient
);

    localparam int CW = $clog2(DVD_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [DVS_W-1:0] r_rem;
    logic [DVD_W-1:0] r_work;
    logic [DVS_W-1:0] r_dvs;
    logic [DVS_W-1:0] n_rem;
    logic [DVD_W-1:0] n_work;
    logic [DVS_W:0]   w_trial;
    logic             w_ge;

    always_comb begin
        w_trial = {r_rem, r_work[DVD_W-1]};
        w_ge    = (w_trial >= {1'b0, r_dvs});
        n_rem   = w_ge ? DVS_W'(w_trial - {1'b0, r_dvs}) : w_trial[DVS_W-1:0];
        n_work  = {r_work[DVD_W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_work <= i_dividend;
            r_dvs  <= i_divisor;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_work <= n_work;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_work;

endmodule
`default_nettype wire
